### hdl/led_sign_pixel_colorizer_assert.svh
// assertion macros for the pixel colorizer
`ifndef LED_SIGN_PIXEL_COLORIZER_ASSERT_SVH
`define LED_SIGN_PIXEL_COLORIZER_ASSERT_SVH

// consequent checked in the same cycle
`define LSPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lspc check failed");

// consequent checked in the cycle after the antecedent
`define LSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lspc check failed");

`endif

### hdl/lspc_pkg.sv
`timescale 1ns / 1ps

package lspc_pkg;

  // colour styles
  typedef enum logic [2:0] {
    StyleSolid     = 3'd0,
    StyleRainbow   = 3'd1,
    StylePalette   = 3'd2,
    StyleBreathe   = 3'd3,
    StyleSparkle   = 3'd4,
    StyleBlink     = 3'd5,
    StyleAlternate = 3'd6
  } lspc_style_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegStyle  = 2'd0,
    RegColorA = 2'd1,
    RegColorB = 2'd2
  } lspc_reg_e;

  // per-stage load enables shared with the sub-units
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lspc_adv_t;

  localparam int unsigned XW   = 6;
  localparam int unsigned YW   = 3;
  localparam int unsigned FW   = 32;
  localparam int unsigned RgbW = 24;

  localparam logic [RgbW-1:0] White = 24'hFFFFFF;
  localparam logic [RgbW-1:0] Black = 24'h000000;

  localparam logic [RgbW-1:0] Palette [4] = '{24'hFF0000, 24'hFFC800, 24'h00FF00, 24'hFFFFFF};

  localparam logic [31:0] HashMulX = 32'd73856093;
  localparam logic [31:0] HashMulY = 32'd19349663;
  // (f - f mod 3) times the inverse of 3 mod 2^32 is f/3 exactly, so this folds both
  localparam logic [31:0] HashMulT = 32'(64'hAAAAAAAB * 64'd83492791);

  // breathe factors, unsigned q1.15
  function automatic logic [15:0] breathe_k(input logic [5:0] idx);
    logic [15:0] k;
    case (idx)
      6'd0:  k = 16'd25395;  6'd1:  k = 16'd26549;  6'd2:  k = 16'd27674;
      6'd3:  k = 16'd28742;  6'd4:  k = 16'd29729;  6'd5:  k = 16'd30609;
      6'd6:  k = 16'd31360;  6'd7:  k = 16'd31964;  6'd8:  k = 16'd32407;
      6'd9:  k = 16'd32677;  6'd10: k = 16'd32768;  6'd11: k = 16'd32677;
      6'd12: k = 16'd32407;  6'd13: k = 16'd31964;  6'd14: k = 16'd31360;
      6'd15: k = 16'd30609;  6'd16: k = 16'd29729;  6'd17: k = 16'd28742;
      6'd18: k = 16'd27674;  6'd19: k = 16'd26549;  6'd20: k = 16'd25395;
      6'd21: k = 16'd24242;  6'd22: k = 16'd23117;  6'd23: k = 16'd22048;
      6'd24: k = 16'd21062;  6'd25: k = 16'd20182;  6'd26: k = 16'd19430;
      6'd27: k = 16'd18826;  6'd28: k = 16'd18383;  6'd29: k = 16'd18113;
      6'd30: k = 16'd18022;  6'd31: k = 16'd18113;  6'd32: k = 16'd18383;
      6'd33: k = 16'd18826;  6'd34: k = 16'd19430;  6'd35: k = 16'd20182;
      6'd36: k = 16'd21062;  6'd37: k = 16'd22048;  6'd38: k = 16'd23117;
      6'd39: k = 16'd24242;
      default: k = 16'd0;
    endcase
    return k;
  endfunction

endpackage

### hdl/led_sign_pixel_colorizer.sv
`timescale 1ns / 1ps

// pixel colour unit for a scrolling led sign: each transfer on the input
// channel carries one pixel (column, row, frame number, lit flag) and yields
// exactly one 24-bit 0xRRGGBB colour on the output channel, in order. it is a
// five-stage pipeline with a valid bit per stage, so one pixel is taken every
// cycle while in_stall_o is low; a stage only holds when it and every stage
// after it are full and the output is stalled, so bubbles are squeezed out
// and in_stall_o rises only when the whole pipe is full. the user must write
// the style and the two colours through the configuration port (index 0
// style, 1 colour a, 2 colour b) only while no pixel is in flight; the block
// does not enforce this. cfg_ready_o is always high and index 3 is ignored.
module led_sign_pixel_colorizer import lspc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // pixel input channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [XW-1:0]   x_pos_i,
  input  logic [YW-1:0]   y_pos_i,
  input  logic [FW-1:0]   frame_count_i,
  input  logic            lit_i,
  // colour output channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [RgbW-1:0] rgb_o,
  // configuration write channel
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [RgbW-1:0] cfg_data_i
);

  localparam int unsigned NumStages = 5;

  // configuration
  logic [2:0]      style_q;
  logic [RgbW-1:0] color_a_q;
  logic [RgbW-1:0] color_b_q;

  // pipeline control
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  lspc_adv_t            adv;

  // stage 1
  logic            lit1_q;
  logic [3:0]      col1_d, col1_q;
  logic [FW-1:0]   f1_q;
  logic [31:0]     hxy1_d, hxy1_q;
  logic [11:0]     col_prod;
  // stage 2
  logic            lit2_q;
  logic [3:0]      col2_q;
  logic [FW-1:0]   f2_q;
  logic [31:0]     hxy2_q;
  logic [1:0]      m3;
  logic [2:0]      m5;
  logic [3:0]      m9;
  // stage 3
  logic            lit3_q;
  logic [1:0]      pal3_d, pal3_q;
  logic            alt3_q;
  logic            blink3_q;
  logic [5:0]      bidx3_q;
  logic [3:0]      spnib3_d, spnib3_q;
  logic [31:0]     spark_h;
  logic [7:0]      crt;
  logic [RgbW-1:0] rain3;
  // stage 4
  logic            lit4_q;
  logic [1:0]      pal4_q;
  logic            alt4_q;
  logic            blink4_q;
  logic            spark4_q;
  logic [15:0]     k4_q;
  logic [RgbW-1:0] rain4_q;
  // stage 5 (output register)
  logic [23:0]     prod_r, prod_g, prod_b;
  logic [RgbW-1:0] rgb_d, rgb_q;

  // ---------------------------------------------------------------------
  // handshake and stage enables: a stage loads when it is empty or the
  // stage behind it moves on
  // ---------------------------------------------------------------------
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign adv.s1 = en[0];
  assign adv.s2 = en[1];
  assign adv.s3 = en[2];

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NumStages-1];
  assign rgb_o       = rgb_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q   <= StyleSolid;
      color_a_q <= Black;
      color_b_q <= Black;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lspc_reg_e'(cfg_index_i))
        RegStyle:  style_q   <= cfg_data_i[2:0];
        RegColorA: color_a_q <= cfg_data_i;
        RegColorB: color_b_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sub-units: frame residues (mod 3, 5, 9) and the hue ramp
  // ---------------------------------------------------------------------
  lspc_residue u_residue (
    .clk_i,
    .adv_i         (adv),
    .frame_count_i (frame_count_i),
    .m3_o          (m3),
    .m5_o          (m5),
    .m9_o          (m9)
  );

  lspc_hue u_hue (
    .clk_i,
    .adv_i       (adv),
    .x_pos_i     (x_pos_i),
    .frame_low_i (frame_count_i[15:0]),
    .rgb_o       (rain3)
  );

  // ---------------------------------------------------------------------
  // stage 1: column (x/6 as x*43>>8, exact for six-bit x) and the
  // position part of the sparkle hash
  // ---------------------------------------------------------------------
  assign col_prod = 12'(x_pos_i) * 12'd43;
  assign col1_d   = col_prod[11:8];
  assign hxy1_d   = (32'(x_pos_i) * HashMulX) ^ (32'(y_pos_i) * HashMulY);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lit1_q <= lit_i;
      col1_q <= col1_d;
      f1_q   <= frame_count_i;
      hxy1_q <= hxy1_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: carry forward while the residues settle
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      lit2_q <= lit1_q;
      col2_q <= col1_q;
      f2_q   <= f1_q;
      hxy2_q <= hxy1_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: frame term of the hash, breathe index by crt from f mod 8
  // and f mod 5, blink phase from f mod 18
  // ---------------------------------------------------------------------
  always_comb begin
    spark_h  = hxy2_q ^ ((f2_q - 32'(m3)) * HashMulT);
    spnib3_d = spark_h[3:0] ^ spark_h[16:13];
    pal3_d   = col2_q[1:0] + f2_q[3:2];
    crt      = 8'(f2_q[2:0]) * 8'd25 + 8'(m5) * 8'd16;
    for (int i = 0; i < 5; i++) begin
      if (crt >= 8'd40) crt = crt - 8'd40;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lit3_q   <= lit2_q;
      pal3_q   <= pal3_d;
      alt3_q   <= col2_q[0];
      // floor(f/9) is odd when f mod 18 >= 9, i.e. parity of f and f mod 9 differ
      blink3_q <= m9[0] ^ f2_q[0];
      bidx3_q  <= crt[5:0];
      spnib3_q <= spnib3_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: breathe factor lookup and sparkle decision
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      lit4_q   <= lit3_q;
      pal4_q   <= pal3_q;
      alt4_q   <= alt3_q;
      blink4_q <= blink3_q;
      spark4_q <= spnib3_q < 4'd2;
      k4_q     <= breathe_k(bidx3_q);
      rain4_q  <= rain3;
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: channel scaling and style select into the output register
  // ---------------------------------------------------------------------
  assign prod_r = 24'(color_a_q[23:16]) * 24'(k4_q);
  assign prod_g = 24'(color_a_q[15:8])  * 24'(k4_q);
  assign prod_b = 24'(color_a_q[7:0])   * 24'(k4_q);

  always_comb begin
    rgb_d = Black;
    if (lit4_q) begin
      case (lspc_style_e'(style_q))
        StyleSolid:     rgb_d = color_a_q;
        StyleRainbow:   rgb_d = rain4_q;
        StylePalette:   rgb_d = Palette[pal4_q];
        StyleBreathe:   rgb_d = {prod_r[22:15], prod_g[22:15], prod_b[22:15]};
        StyleSparkle:   rgb_d = spark4_q ? White : color_a_q;
        StyleBlink:     rgb_d = blink4_q ? Black : color_a_q;
        StyleAlternate: rgb_d = alt4_q ? color_b_q : color_a_q;
        default:        rgb_d = Black;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) rgb_q <= rgb_d;
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `include "led_sign_pixel_colorizer_assert.svh"

  `LSPC_ASSERT_SAME(a_stall_only_when_full, in_stall_o, (&v_q))
  `LSPC_ASSERT_NEXT(a_unlit_black, v_q[3] && en[4] && !lit4_q, rgb_o == Black)
  `LSPC_ASSERT_NEXT(a_solid_colour, v_q[3] && en[4] && lit4_q && style_q == StyleSolid, rgb_o == color_a_q)

endmodule

### hdl/lspc_residue.sv
`timescale 1ns / 1ps

module lspc_residue import lspc_pkg::*; (
  input  logic          clk_i,
  input  lspc_adv_t     adv_i,
  input  logic [FW-1:0] frame_count_i,
  output logic [1:0]    m3_o,
  output logic [2:0]    m5_o,
  output logic [3:0]    m9_o
);

  logic [6:0] nsum_d, nsum_q;
  logic [8:0] csum_d, csum_q;
  logic [4:0] a16;
  logic [4:0] r5;
  logic [4:0] r3;
  logic [6:0] r9;
  logic [1:0] m3_q;
  logic [2:0] m5_q;
  logic [3:0] m9_q;

  // 16 = 1 mod 3 and mod 5, 64 = 1 mod 9: digit sums keep the residues
  always_comb begin
    nsum_d = 7'(frame_count_i[3:0])   + 7'(frame_count_i[7:4])
           + 7'(frame_count_i[11:8])  + 7'(frame_count_i[15:12])
           + 7'(frame_count_i[19:16]) + 7'(frame_count_i[23:20])
           + 7'(frame_count_i[27:24]) + 7'(frame_count_i[31:28]);
    csum_d = 9'(frame_count_i[5:0])   + 9'(frame_count_i[11:6])
           + 9'(frame_count_i[17:12]) + 9'(frame_count_i[23:18])
           + 9'(frame_count_i[29:24]) + 9'(frame_count_i[31:30]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      nsum_q <= nsum_d;
      csum_q <= csum_d;
    end
  end

  always_comb begin
    a16 = 5'(nsum_q[6:4]) + 5'(nsum_q[3:0]);
    r5  = a16;
    for (int i = 0; i < 4; i++) begin
      if (r5 >= 5'd5) r5 = r5 - 5'd5;
    end
    r3 = a16;
    for (int i = 0; i < 7; i++) begin
      if (r3 >= 5'd3) r3 = r3 - 5'd3;
    end
    r9 = 7'(csum_q[8:6]) + 7'(csum_q[5:0]);
    for (int i = 0; i < 7; i++) begin
      if (r9 >= 7'd9) r9 = r9 - 7'd9;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      m3_q <= r3[1:0];
      m5_q <= r5[2:0];
      m9_q <= r9[3:0];
    end
  end

  assign m3_o = m3_q;
  assign m5_o = m5_q;
  assign m9_o = m9_q;

endmodule

### hdl/lspc_hue.sv
`timescale 1ns / 1ps

module lspc_hue import lspc_pkg::*; (
  input  logic            clk_i,
  input  lspc_adv_t       adv_i,
  input  logic [XW-1:0]   x_pos_i,
  input  logic [15:0]     frame_low_i,
  output logic [RgbW-1:0] rgb_o
);

  logic [15:0]     hue_d, hue_q;
  logic [26:0]     prod;
  logic [10:0]     h_d, h_q;
  logic [10:0]     rr, gg, bb;
  logic [RgbW-1:0] rgb_d, rgb_q;

  // hue wraps modulo 2^16
  assign hue_d = 16'(x_pos_i) * 16'd1200 + frame_low_i * 16'd400;

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) hue_q <= hue_d;
  end

  // scale to 0..1530 with rounding
  assign prod = 27'(hue_q) * 27'd1530 + 27'd32768;
  assign h_d  = prod[26:16];

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) h_q <= h_d;
  end

  always_comb begin
    rr = 11'd0;
    gg = 11'd0;
    bb = 11'd0;
    if (h_q < 11'd510) begin
      if (h_q < 11'd255) begin
        rr = 11'd255;
        gg = h_q;
      end else begin
        rr = 11'd510 - h_q;
        gg = 11'd255;
      end
    end else if (h_q < 11'd1020) begin
      if (h_q < 11'd765) begin
        gg = 11'd255;
        bb = h_q - 11'd510;
      end else begin
        gg = 11'd1020 - h_q;
        bb = 11'd255;
      end
    end else if (h_q < 11'd1530) begin
      if (h_q < 11'd1275) begin
        rr = h_q - 11'd1020;
        bb = 11'd255;
      end else begin
        rr = 11'd255;
        bb = 11'd1530 - h_q;
      end
    end else begin
      rr = 11'd255;
    end
    rgb_d = {rr[7:0], gg[7:0], bb[7:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) rgb_q <= rgb_d;
  end

  assign rgb_o = rgb_q;

endmodule

### tb/tb_led_sign_pixel_colorizer.sv
`timescale 1ns / 1ps

module tb_led_sign_pixel_colorizer;
  import lspc_pkg::*;

  // index 3 has no register behind it, writes there must be ignored
  localparam logic [1:0] RegUnused = 2'd3;

  // hash multipliers of the sparkle style; the frame term uses the plain frame / 3
  localparam logic [31:0] SparkleMulX = 32'd73856093;
  localparam logic [31:0] SparkleMulY = 32'd19349663;
  localparam logic [31:0] SparkleMulT = 32'd83492791;

  // fixed colours of the palette style: red, amber, green, white
  localparam logic [23:0] PaletteColour [4] = '{24'hFF0000, 24'hFFC800, 24'h00FF00, 24'hFFFFFF};

  // breathe factors in unsigned q1.15, one per frame modulo 40
  localparam logic [15:0] BreatheFactor [40] = '{
    16'd25395, 16'd26549, 16'd27674, 16'd28742, 16'd29729, 16'd30609, 16'd31360, 16'd31964,
    16'd32407, 16'd32677, 16'd32768, 16'd32677, 16'd32407, 16'd31964, 16'd31360, 16'd30609,
    16'd29729, 16'd28742, 16'd27674, 16'd26549, 16'd25395, 16'd24242, 16'd23117, 16'd22048,
    16'd21062, 16'd20182, 16'd19430, 16'd18826, 16'd18383, 16'd18113, 16'd18022, 16'd18113,
    16'd18383, 16'd18826, 16'd19430, 16'd20182, 16'd21062, 16'd22048, 16'd23117, 16'd24242
  };

  // colour predictor with its own copy of the registers, plus the queue of
  // colours still owed by the pipeline
  class rgb_scoreboard;
    logic [2:0]  style;
    logic [23:0] colour_a;
    logic [23:0] colour_b;
    logic [23:0] owed_rgb_q [$];
    int unsigned fault_count;

    function new();
      style       = 3'd0;
      colour_a    = 24'h000000;
      colour_b    = 24'h000000;
      fault_count = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [23:0] data);
      case (index)
        RegStyle:  style    = data[2:0];
        RegColorA: colour_a = data;
        RegColorB: colour_b = data;
        default: ;
      endcase
    endfunction

    // saturated hue ramp, h runs 0..1530 with 1530 folding back to red
    function logic [23:0] hue_colour(logic [15:0] hue16);
      logic [31:0] h;
      logic [31:0] r, g, b;
      h = (32'(hue16) * 32'd1530 + 32'd32768) >> 16;
      if (h < 510) begin
        b = 0;
        if (h < 255) begin
          r = 255; g = h;
        end else begin
          r = 510 - h; g = 255;
        end
      end else if (h < 1020) begin
        r = 0;
        if (h < 765) begin
          g = 255; b = h - 510;
        end else begin
          g = 1020 - h; b = 255;
        end
      end else if (h < 1530) begin
        g = 0;
        if (h < 1275) begin
          r = h - 1020; b = 255;
        end else begin
          r = 255; b = 1530 - h;
        end
      end else begin
        r = 255; g = 0; b = 0;
      end
      return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function logic [23:0] colorize(logic [XW-1:0] x, logic [YW-1:0] y, logic [FW-1:0] f,
                                   logic lit_bit);
      logic [31:0] column;
      logic [31:0] hash;
      logic [31:0] r, g, b;
      logic [15:0] k;
      logic [23:0] rgb_val;
      column  = 32'(x) / 32'd6;
      rgb_val = Black;
      if (lit_bit) begin
        case (style)
          StyleSolid:   rgb_val = colour_a;
          StyleRainbow: rgb_val = hue_colour(16'(32'(x) * 32'd1200 + f * 32'd400));
          StylePalette: rgb_val = PaletteColour[2'(column + f / 32'd4)];
          StyleBreathe: begin
            k = BreatheFactor[f % 32'd40];
            r = (32'(colour_a[23:16]) * 32'(k)) >> 15;
            g = (32'(colour_a[15:8]) * 32'(k)) >> 15;
            b = (32'(colour_a[7:0]) * 32'(k)) >> 15;
            rgb_val = {r[7:0], g[7:0], b[7:0]};
          end
          StyleSparkle: begin
            hash = (32'(x) * SparkleMulX) ^ (32'(y) * SparkleMulY) ^ ((f / 32'd3) * SparkleMulT);
            hash = hash ^ (hash >> 13);
            rgb_val = (hash[3:0] < 4'd2) ? White : colour_a;
          end
          StyleBlink:     rgb_val = ((f / 32'd9) & 32'd1) != 0 ? Black : colour_a;
          StyleAlternate: rgb_val = column[0] ? colour_b : colour_a;
          default:        rgb_val = Black;
        endcase
      end
      return rgb_val;
    endfunction

    function void note_pixel(logic [XW-1:0] x, logic [YW-1:0] y, logic [FW-1:0] f,
                             logic lit_bit);
      owed_rgb_q.push_back(colorize(x, y, f, lit_bit));
    endfunction

    function void check_rgb(logic [23:0] actual);
      logic [23:0] owed;
      if (owed_rgb_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected colour %06h at %0t ns, nothing owed", actual, $time);
        return;
      end
      owed = owed_rgb_q.pop_front();
      if (actual !== owed) begin
        fault_count++;
        if (fault_count <= 10)
          $display("colour mismatch at %0t ns: expected %06h, got %06h", $time, owed, actual);
      end
    endfunction

    function int pending();
      return owed_rgb_q.size();
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [XW-1:0]   x_pos;
  logic [YW-1:0]   y_pos;
  logic [FW-1:0]   frame_count;
  logic            lit;
  logic            out_valid;
  logic            out_stall;
  logic [RgbW-1:0] rgb;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [RgbW-1:0] cfg_data;

  rgb_scoreboard sb;

  // receiver stall pattern state
  int unsigned stall_mode;
  int unsigned stall_mode_left;
  int unsigned hold_left;
  logic        hold_stall;

  led_sign_pixel_colorizer i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .x_pos_i       (x_pos),
    .y_pos_i       (y_pos),
    .frame_count_i (frame_count),
    .lit_i         (lit),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .rgb_o         (rgb),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #10_000_000;
    $display("tb_led_sign_pixel_colorizer: done, errors");
    $finish;
  end

  // all three channels observed at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(x_pos, y_pos, frame_count, lit);
    if (rst_n && out_valid && !out_stall) sb.check_rgb(rgb);
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  // receiver: free-running, light, heavy and long-hold stall stretches
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_stall = ~hold_stall;
          hold_left  = $urandom_range(1, 16);
        end else begin
          hold_left--;
        end
        out_stall <= hold_stall;
      end
    endcase
  end

  // one pixel transfer; payload held until the block takes it
  task automatic send_pixel(input logic [XW-1:0] x, input logic [YW-1:0] y,
                            input logic [FW-1:0] f, input logic lit_bit);
    @(negedge clk);
    in_valid    <= 1'b1;
    x_pos       <= x;
    y_pos       <= y;
    frame_count <= f;
    lit         <= lit_bit;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // stop sending, let every owed colour come out, then allow for the pipe depth
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only ever issued with the pipe empty
  task automatic configure(input logic [1:0] index, input logic [23:0] data);
    drain_pipe();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // frame numbers: anywhere, small, or just short of the wrap
  function automatic logic [31:0] rand_frame();
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 200));
      1:       return 32'hFFFFFFFF - 32'($urandom_range(0, 100));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [23:0] rand_colour(input int unsigned sel);
    case (sel % 4)
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned red_frame;
    int unsigned phase;
    int unsigned n;
    int unsigned items;
    int unsigned burst_left;
    logic [2:0]  style_pick;

    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    x_pos       = '0;
    y_pos       = '0;
    frame_count = '0;
    lit         = 1'b0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = RegStyle;
    cfg_data    = '0;
    stall_mode      = 0;
    stall_mode_left = 0;
    hold_left       = 0;
    hold_stall      = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset registers: solid style with a black primary colour
    send_pixel(6'd63, 3'd7, 32'hFFFFFFFF, 1'b1);

    // solid, full white, then an unlit pixel which must stay black
    configure(RegColorA, 24'hFFFFFF);
    configure(RegColorB, 24'h000000);
    configure(RegStyle, 24'(StyleSolid));
    send_pixel(6'd63, 3'd7, 32'hFFFFFFFF, 1'b1);
    send_pixel(6'd0, 3'd0, 32'd0, 1'b0);

    // rainbow: find a frame whose hue lands on the top of the ramp (pure red again)
    red_frame = 0;
    while (((red_frame * 400) & 32'hFFFF) != 32'd65520) red_frame++;
    configure(RegStyle, 24'(StyleRainbow));
    send_pixel(6'd0, 3'd0, 32'(red_frame), 1'b1);
    send_pixel(6'd63, 3'd7, 32'hFFFFFFFF, 1'b1);
    send_pixel(6'd5, 3'd3, 32'd0, 1'b1);

    configure(RegStyle, 24'(StylePalette));
    send_pixel(6'd0, 3'd0, 32'd0, 1'b1);
    send_pixel(6'd6, 3'd0, 32'd4, 1'b1);
    send_pixel(6'd63, 3'd7, 32'hFFFFFFFF, 1'b1);

    // breathe at the peak factor, the trough and across the frame wrap
    configure(RegStyle, 24'(StyleBreathe));
    send_pixel(6'd1, 3'd1, 32'd10, 1'b1);
    send_pixel(6'd2, 3'd2, 32'd30, 1'b1);
    send_pixel(6'd63, 3'd7, 32'hFFFFFFFF, 1'b1);

    configure(RegStyle, 24'(StyleSparkle));
    send_pixel(6'd0, 3'd0, 32'd0, 1'b1);
    send_pixel(6'd63, 3'd7, 32'hFFFFFFFF, 1'b1);
    send_pixel(6'd17, 3'd5, 32'h12345678, 1'b1);

    // blink either side of the 9-frame toggle
    configure(RegStyle, 24'(StyleBlink));
    send_pixel(6'd0, 3'd0, 32'd8, 1'b1);
    send_pixel(6'd0, 3'd0, 32'd9, 1'b1);
    send_pixel(6'd63, 3'd7, 32'hFFFFFFFF, 1'b1);

    configure(RegColorA, 24'h000000);
    configure(RegColorB, 24'hFFFFFF);
    configure(RegStyle, 24'(StyleAlternate));
    send_pixel(6'd0, 3'd0, 32'd0, 1'b1);
    send_pixel(6'd6, 3'd0, 32'd0, 1'b1);
    send_pixel(6'd63, 3'd7, 32'd0, 1'b1);

    // unused style code gives black even for lit pixels; index 3 is a no-op
    configure(RegStyle, 24'd7);
    configure(RegUnused, 24'hFFFFFF);
    send_pixel(6'd10, 3'd2, 32'd100, 1'b1);
    send_pixel(6'd10, 3'd2, 32'd100, 1'b0);

    // random phases: every style in turn first, then random ones, each phase
    // starting from an empty pipe so the sender pauses for all owed colours
    burst_left = 0;
    for (phase = 0; phase < 16; phase++) begin
      style_pick = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
      configure(RegColorA, rand_colour(phase));
      configure(RegColorB, rand_colour(phase + 1));
      // upper data bits are junk, only the low three select the style
      configure(RegStyle, {21'($urandom()), style_pick});
      if (phase % 5 == 0) configure(RegUnused, 24'($urandom()));
      items = $urandom_range(105, 120);
      for (n = 0; n < items; n++) begin
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0:       idle_gap(0);
            1:       idle_gap($urandom_range(1, 3));
            2:       idle_gap($urandom_range(4, 12));
            default: idle_gap(0);
          endcase
          burst_left = $urandom_range(1, 40);
        end
        send_pixel(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), rand_frame(),
                   ($urandom_range(0, 4) != 0));
        burst_left--;
      end
    end

    drain_pipe();
    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("tb_led_sign_pixel_colorizer: done, clean");
    end else begin
      $display("tb_led_sign_pixel_colorizer: done, errors");
    end
    $finish;
  end

endmodule
